@@ design/mlbs_pkg.sv @@
// Shared op codes, LED modes and the queued command type of the LED blink scanner.
`default_nettype none
package mlbs_pkg;

  localparam int unsigned CNT_W = 16;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = $clog2(QDEPTH);

  localparam logic [3:0] OP_TICK    = 4'd0;
  localparam logic [3:0] OP_ON      = 4'd1;
  localparam logic [3:0] OP_OFF     = 4'd2;
  localparam logic [3:0] OP_TOGGLE  = 4'd3;
  localparam logic [3:0] OP_TIMED   = 4'd4;
  localparam logic [3:0] OP_COUNTED = 4'd5;
  localparam logic [3:0] OP_ENDLESS = 4'd6;
  localparam logic [3:0] OP_STOP    = 4'd7;
  localparam logic [3:0] OP_CLEAR   = 4'd8;

  localparam logic [1:0] MODE_STEADY  = 2'd0;
  localparam logic [1:0] MODE_COUNTED = 2'd1;
  localparam logic [1:0] MODE_ENDLESS = 2'd2;
  localparam logic [1:0] MODE_TIMED   = 2'd3;

  typedef struct packed {
    logic [3:0]       op;
    logic [1:0]       led;
    logic [CNT_W-1:0] val_a;    // start count: on time in counts, or half period
    logic [CNT_W-1:0] val_b;    // off reload in counts
    logic [CNT_W-1:0] toggles;
  } mlbs_cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } mlbs_wr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } mlbs_rd_t;

endpackage
`default_nettype wire

@@ design/multiplexed_led_blink_scanner_top.sv @@
// Top level of the multiplexed three-LED blink scanner.
//
// Input channel (in_*): one request per accepted cycle. Op tick returns the
// drive line code of the scanned LED, steps that LED's timer and moves the
// scan on; the other ops change one LED (or clear all) and return nothing.
// Unknown ops and per-LED ops on an LED index out of range are dropped.
// Result channel (out_*): out_line_one / out_line_two for each tick, in order.
// Counted blinks whose period is shorter than their on time are dropped too.
// A tick is held in the 4-entry queue, then its result is registered.
// Throughput: one request per cycle while in_stall is low, set by the single
// state update per cycle in the back end; other ops drain while a result waits.
// Stall: while out_stall holds, a waiting result stays put; later ticks wait
// in the queue and in_stall rises once the queue is full.
// Reset (rst_n low, synchronous): all LEDs dark and steady, counters, reloads
// and toggle counts zero, scan at the first LED, queue empty.
`default_nettype none
module multiplexed_led_blink_scanner_top #(
  parameter int unsigned NUM_LEDS     = 3,
  parameter int unsigned MS_PER_COUNT = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [3:0]  in_op,
  input  wire logic [1:0]  in_led,
  input  wire logic [15:0] in_on_time_ms,
  input  wire logic [15:0] in_period_ms,
  input  wire logic [15:0] in_blink_count,
  input  wire logic [15:0] in_half_period,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        out_line_one,
  output      logic        out_line_two
);

  mlbs_pkg::mlbs_cmd_t front_cmd;
  mlbs_pkg::mlbs_cmd_t head_cmd;
  mlbs_pkg::mlbs_wr_t  wr_stat;
  mlbs_pkg::mlbs_rd_t  rd_stat;
  logic                push;
  logic                pop;
  logic                accept;

  assign accept   = in_valid & ~in_stall;
  assign in_stall = wr_stat.full;

  mlbs_front #(
    .NUM_LEDS     (NUM_LEDS),
    .MS_PER_COUNT (MS_PER_COUNT)
  ) u_front (
    .accept      (accept),
    .op          (in_op),
    .led         (in_led),
    .on_time_ms  (in_on_time_ms),
    .period_ms   (in_period_ms),
    .blink_count (in_blink_count),
    .half_period (in_half_period),
    .push        (push),
    .cmd         (front_cmd)
  );

  mlbs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_cmd  (front_cmd),
    .pop     (pop),
    .rd_cmd  (head_cmd),
    .wr_stat (wr_stat),
    .rd_stat (rd_stat)
  );

  mlbs_back #(
    .NUM_LEDS (NUM_LEDS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (head_cmd),
    .empty        (rd_stat.empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_line_one (out_line_one),
    .out_line_two (out_line_two)
  );

endmodule
`default_nettype wire

@@ design/mlbs_front.sv @@
// Front end: decodes requests, scales millisecond lengths and drops invalid requests.
`default_nettype none
module mlbs_front #(
  parameter int unsigned NUM_LEDS     = 3,
  parameter int unsigned MS_PER_COUNT = 20
) (
  input  wire logic                   accept,
  input  wire logic [3:0]             op,
  input  wire logic [1:0]             led,
  input  wire logic [15:0]            on_time_ms,
  input  wire logic [15:0]            period_ms,
  input  wire logic [15:0]            blink_count,
  input  wire logic [15:0]            half_period,
  output      logic                   push,
  output      mlbs_pkg::mlbs_cmd_t    cmd
);

  // Exact reciprocal for 16-bit dividends: shift = 16 + ceil(log2(divisor)).
  localparam int unsigned K  = 16 + $clog2(MS_PER_COUNT);
  localparam int unsigned PW = K + 16;
  localparam logic [PW-1:0] RECIP =
    PW'(((64'd1 << K) + 64'(MS_PER_COUNT) - 64'd1) / 64'(MS_PER_COUNT));

  logic [PW-1:0] on_prod;
  logic [PW-1:0] per_prod;
  logic [15:0]   on_cnt;
  logic [15:0]   per_cnt;
  logic          led_ok;
  logic          keep;

  assign on_prod  = PW'(on_time_ms) * RECIP;
  assign per_prod = PW'(period_ms) * RECIP;
  assign on_cnt   = 16'(on_prod >> K);
  assign per_cnt  = 16'(per_prod >> K);
  assign led_ok   = 32'(led) < NUM_LEDS;

  always_comb begin
    case (op)
      mlbs_pkg::OP_TICK, mlbs_pkg::OP_CLEAR: keep = 1'b1;
      mlbs_pkg::OP_ON, mlbs_pkg::OP_OFF, mlbs_pkg::OP_TOGGLE, mlbs_pkg::OP_TIMED,
      mlbs_pkg::OP_ENDLESS, mlbs_pkg::OP_STOP: keep = led_ok;
      // drop a counted blink whose period is shorter than its on time
      mlbs_pkg::OP_COUNTED: keep = led_ok && !(per_cnt < on_cnt);
      default: keep = 1'b0;
    endcase
  end

  assign push        = accept & keep;
  assign cmd.op      = op;
  assign cmd.led     = led;
  assign cmd.val_a   = (op == mlbs_pkg::OP_ENDLESS) ? half_period : on_cnt;
  assign cmd.val_b   = per_cnt;
  assign cmd.toggles = {blink_count[14:0], 1'b0};

endmodule
`default_nettype wire

@@ design/mlbs_queue.sv @@
// Short command queue between the front end and the LED state engine.
`default_nettype none
module mlbs_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire mlbs_pkg::mlbs_cmd_t wr_cmd,
  input  wire logic                pop,
  output      mlbs_pkg::mlbs_cmd_t rd_cmd,
  output      mlbs_pkg::mlbs_wr_t  wr_stat,
  output      mlbs_pkg::mlbs_rd_t  rd_stat
);

  mlbs_pkg::mlbs_cmd_t           entry_r [mlbs_pkg::QDEPTH];
  logic [mlbs_pkg::QAW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [mlbs_pkg::QAW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [mlbs_pkg::QAW:0]        count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (mlbs_pkg::QAW+1)'(push) - (mlbs_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_cmd;
    end
  end

  assign rd_cmd        = entry_r[rd_ptr_r];
  assign wr_stat.push  = push;
  assign wr_stat.full  = count_r == (mlbs_pkg::QAW+1)'(mlbs_pkg::QDEPTH);
  assign rd_stat.pop   = pop;
  assign rd_stat.empty = count_r == '0;

endmodule
`default_nettype wire

@@ design/mlbs_back.sv @@
// Back end: per-LED state, tick stepping, scan position and the result register.
`default_nettype none
module mlbs_back #(
  parameter int unsigned NUM_LEDS = 3
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mlbs_pkg::mlbs_cmd_t cmd,
  input  wire logic                empty,
  output      logic                pop,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      logic                out_line_one,
  output      logic                out_line_two
);

  logic [NUM_LEDS-1:0] lit_r, lit_nxt;
  logic [1:0]          mode_r    [NUM_LEDS];
  logic [1:0]          mode_nxt  [NUM_LEDS];
  logic [15:0]         cnt_r     [NUM_LEDS];
  logic [15:0]         cnt_nxt   [NUM_LEDS];
  logic [15:0]         onr_r     [NUM_LEDS];
  logic [15:0]         onr_nxt   [NUM_LEDS];
  logic [15:0]         offr_r    [NUM_LEDS];
  logic [15:0]         offr_nxt  [NUM_LEDS];
  logic [15:0]         tog_r     [NUM_LEDS];
  logic [15:0]         tog_nxt   [NUM_LEDS];
  logic [1:0]          scan_r, scan_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                line_one_r, line_two_r;
  logic                is_tick;
  logic                slot_free;
  logic                scan_lit;
  logic [1:0]          code;

  assign is_tick   = cmd.op == mlbs_pkg::OP_TICK;
  assign slot_free = !out_valid_r || !out_stall;
  // a tick needs the result slot; other requests drain freely
  assign pop       = !empty && (!is_tick || slot_free);
  assign code      = scan_r + 2'd1;

  always_comb begin
    scan_lit = 1'b0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      if (scan_r == 2'(i)) begin
        scan_lit = lit_r[i];
      end
    end
  end

  always_comb begin
    logic [15:0] dec;
    logic [15:0] tdec;
    dec  = '0;
    tdec = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      lit_nxt[i]  = lit_r[i];
      mode_nxt[i] = mode_r[i];
      cnt_nxt[i]  = cnt_r[i];
      onr_nxt[i]  = onr_r[i];
      offr_nxt[i] = offr_r[i];
      tog_nxt[i]  = tog_r[i];
      dec  = cnt_r[i] - 16'd1;
      tdec = tog_r[i] - 16'd1;
      if (pop) begin
        case (cmd.op)
          mlbs_pkg::OP_TICK: begin
            if (scan_r == 2'(i) && mode_r[i] != mlbs_pkg::MODE_STEADY) begin
              cnt_nxt[i] = dec;
              if (dec == '0) begin
                case (mode_r[i])
                  mlbs_pkg::MODE_COUNTED: begin
                    tog_nxt[i] = tdec;
                    if (tdec == '0) begin
                      lit_nxt[i]  = 1'b0;
                      mode_nxt[i] = mlbs_pkg::MODE_STEADY;
                    end else begin
                      cnt_nxt[i] = lit_r[i] ? offr_r[i] : onr_r[i];
                      lit_nxt[i] = !lit_r[i];
                    end
                  end
                  mlbs_pkg::MODE_ENDLESS: begin
                    cnt_nxt[i] = onr_r[i];
                    lit_nxt[i] = !lit_r[i];
                  end
                  default: begin
                    lit_nxt[i]  = 1'b0;
                    mode_nxt[i] = mlbs_pkg::MODE_STEADY;
                  end
                endcase
              end
            end
          end
          mlbs_pkg::OP_CLEAR: begin
            lit_nxt[i]  = 1'b0;
            mode_nxt[i] = mlbs_pkg::MODE_STEADY;
            cnt_nxt[i]  = '0;
            onr_nxt[i]  = '0;
            offr_nxt[i] = '0;
            tog_nxt[i]  = '0;
          end
          default: begin
            if (cmd.led == 2'(i)) begin
              case (cmd.op)
                mlbs_pkg::OP_ON, mlbs_pkg::OP_OFF, mlbs_pkg::OP_TOGGLE: begin
                  lit_nxt[i]  = (cmd.op == mlbs_pkg::OP_ON) ? 1'b1 :
                                (cmd.op == mlbs_pkg::OP_OFF) ? 1'b0 : !lit_r[i];
                  mode_nxt[i] = mlbs_pkg::MODE_STEADY;
                  cnt_nxt[i]  = '0;
                end
                mlbs_pkg::OP_TIMED: begin
                  lit_nxt[i]  = 1'b1;
                  mode_nxt[i] = mlbs_pkg::MODE_TIMED;
                  cnt_nxt[i]  = cmd.val_a;
                end
                mlbs_pkg::OP_COUNTED: begin
                  lit_nxt[i]  = 1'b1;
                  mode_nxt[i] = mlbs_pkg::MODE_COUNTED;
                  cnt_nxt[i]  = cmd.val_a;
                  onr_nxt[i]  = cmd.val_a;
                  offr_nxt[i] = cmd.val_b;
                  tog_nxt[i]  = cmd.toggles;
                end
                mlbs_pkg::OP_ENDLESS: begin
                  lit_nxt[i]  = 1'b1;
                  mode_nxt[i] = mlbs_pkg::MODE_ENDLESS;
                  cnt_nxt[i]  = cmd.val_a;
                  onr_nxt[i]  = cmd.val_a;
                end
                mlbs_pkg::OP_STOP: begin
                  lit_nxt[i]  = 1'b0;
                  mode_nxt[i] = mlbs_pkg::MODE_STEADY;
                end
                default: begin
                end
              endcase
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    scan_nxt      = scan_r;
    out_valid_nxt = out_valid_r;
    if (pop && is_tick) begin
      scan_nxt      = (scan_r == 2'(NUM_LEDS - 1)) ? 2'd0 : scan_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r       <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        mode_r[i] <= mlbs_pkg::MODE_STEADY;
        cnt_r[i]  <= '0;
        onr_r[i]  <= '0;
        offr_r[i] <= '0;
        tog_r[i]  <= '0;
      end
    end else begin
      lit_r       <= lit_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM_LEDS; i++) begin
        mode_r[i] <= mode_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
        onr_r[i]  <= onr_nxt[i];
        offr_r[i] <= offr_nxt[i];
        tog_r[i]  <= tog_nxt[i];
      end
    end
  end

  // capture the line code from the state before the step
  always_ff @(posedge clk) begin
    if (pop && is_tick) begin
      line_one_r <= scan_lit & code[0];
      line_two_r <= scan_lit & code[1];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_line_one = line_one_r;
  assign out_line_two = line_two_r;

endmodule
`default_nettype wire

@@ design/mlbs_checker.sv @@
// Port-level checks for the LED blink scanner, bound to the top level.
`default_nettype none
module mlbs_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_line_one,
  input wire logic out_line_two
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_line_one) && $stable(out_line_two))
    else $error("stalled result changed or dropped");

  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_queue_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // the queue only fills from accepted requests, so it cannot go full from idle
  a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stall rose without an incoming request");

endmodule

bind multiplexed_led_blink_scanner_top mlbs_checker u_mlbs_checker (.*);
`default_nettype wire
